// ===== hdl/lskv_pkg.sv =====
// Shared types and constants for the linear-search key-value table.
// Used by every module under hdl; depends on nothing.
package lskv_pkg;

    localparam int DEF_CAPACITY    = 1024;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    // Widest slot index for the largest supported capacity (65536 entries).
    localparam int SLOT_W  = 16;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [DATA_W-1:0]  t_data;
    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_ERASE  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode            opcode;
        logic signed [31:0] key;
        logic               write_enable;
        t_data              write_data;
    } t_req;

    typedef struct packed {
        t_data   read_data;
        logic    found;
        t_status status;
        t_count  entry_count;
    } t_rsp;

    // Update command broadcast to every cell of the chain.
    typedef struct packed {
        logic  write;  // load key/value into the cell at slot
        logic  shift;  // cells at or above slot take their upper neighbor
        t_slot slot;
    } t_cell_ctl;

endpackage

// ===== hdl/lskv_cell.sv =====
// One entry cell of the table chain: holds a key and a value, flags a match.
// Depends on lskv_pkg.
module lskv_cell #(
    parameter int INDEX       = 0,
    parameter int KEY_WIDTH   = lskv_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = lskv_pkg::DEF_VALUE_WIDTH,
    parameter int CNT_W       = 11
) (
    input  logic                   i_clk,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [KEY_WIDTH-1:0]   i_cmp_key,
    input  lskv_pkg::t_cell_ctl    i_ctl,
    input  logic [KEY_WIDTH-1:0]   i_wr_key,
    input  logic [VALUE_WIDTH-1:0] i_wr_value,
    input  logic [KEY_WIDTH-1:0]   i_up_key,
    input  logic [VALUE_WIDTH-1:0] i_up_value,
    output logic [KEY_WIDTH-1:0]   o_key,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_hit
);

    localparam lskv_pkg::t_slot MY_SLOT = lskv_pkg::t_slot'(INDEX);

    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_value;
    logic                   w_occupied;

    assign w_occupied = CNT_W'(INDEX) < i_count;
    assign o_hit      = w_occupied && (r_key == i_cmp_key);
    assign o_key      = r_key;
    assign o_value    = r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.write && (i_ctl.slot == MY_SLOT)) begin
            r_key   <= i_wr_key;
            r_value <= i_wr_value;
        end else if (i_ctl.shift && (MY_SLOT >= i_ctl.slot)) begin
            // close the gap left by an erased entry
            r_key   <= i_up_key;
            r_value <= i_up_value;
        end
    end

endmodule

// ===== hdl/lskv_match_enc.sv =====
// Match encoder: turns the one-hot cell hit vector into a slot and a value.
// Keys are unique in the table, so at most one cell hits. Depends on lskv_pkg.
module lskv_match_enc #(
    parameter int CAPACITY    = lskv_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = lskv_pkg::DEF_VALUE_WIDTH,
    parameter int IDX_W       = 10
) (
    input  logic                   i_hit   [CAPACITY],
    input  logic [VALUE_WIDTH-1:0] i_value [CAPACITY],
    output logic                   o_any,
    output logic [IDX_W-1:0]       o_idx,
    output logic [VALUE_WIDTH-1:0] o_value
);

    always_comb begin
        o_any   = 1'b0;
        o_idx   = '0;
        o_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_hit[i]) begin
                o_any   = 1'b1;
                o_idx   = o_idx | IDX_W'(i);
                o_value = o_value | i_value[i];
            end
        end
    end

endmodule

// ===== hdl/linear_search_key_value_table.sv =====
// Linear-search key-value table: top level with the cell chain and control.
// Depends on lskv_pkg, lskv_cell and lskv_match_enc.
//
// Usage:
//   Raise start with a request on i_req (opcode, key, write_enable,
//   write_data). The request is taken at a rising edge where start is high
//   and busy is low. Opcodes: access (find or append, optional write),
//   lookup (read only), erase (remove and pack later entries down), clear.
//   Every request yields exactly one response on o_rsp, marked by o_valid
//   for a single cycle. The receiver has no way to stall; it must take the
//   response in that cycle. o_valid and o_rsp are registered at the end
//   of the update cycle, and no new request is taken while busy is high.
//   In the request cycle every cell compares its key against i_req.key and
//   the match encoder's slot and value are registered; in the update cycle
//   the update is broadcast down the chain (write one cell, or shift all
//   cells at or above the erased slot). The response register is separate,
//   so the next request is taken while the previous response is shown.
//   Reset (i_rst_n low, synchronous) empties the table and drops any
//   request in flight; the key and value cells themselves are not cleared,
//   since the fill count alone marks which of them hold entries.
module linear_search_key_value_table #(
    parameter int CAPACITY    = lskv_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH   = lskv_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = lskv_pkg::DEF_VALUE_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  lskv_pkg::t_req i_req,
    output logic           o_valid,
    output lskv_pkg::t_rsp o_rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // request and match registers
    logic                   r_busy;
    lskv_pkg::t_req         r_req;
    logic                   r_hit_any;
    logic [IDX_W-1:0]       r_hit_idx;
    logic [VALUE_WIDTH-1:0] r_hit_val;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_valid;
    lskv_pkg::t_rsp         r_rsp;
    lskv_pkg::t_rsp         n_rsp;

    logic                   w_accept;
    logic [KEY_WIDTH-1:0]   w_cmp_key;
    logic [KEY_WIDTH-1:0]   w_wr_key;
    logic [VALUE_WIDTH-1:0] w_wr_data;
    logic [VALUE_WIDTH-1:0] w_rd_val;
    lskv_pkg::t_cell_ctl    w_ctl;

    logic                   w_hit      [CAPACITY];
    logic [KEY_WIDTH-1:0]   w_cell_key [CAPACITY];
    logic [VALUE_WIDTH-1:0] w_cell_val [CAPACITY];
    logic                   w_any;
    logic [IDX_W-1:0]       w_idx;
    logic [VALUE_WIDTH-1:0] w_val;

    assign w_accept  = start && !r_busy;
    assign busy      = r_busy;
    assign w_cmp_key = KEY_WIDTH'($unsigned(i_req.key));
    assign w_wr_key  = KEY_WIDTH'($unsigned(r_req.key));
    assign w_wr_data = VALUE_WIDTH'(r_req.write_data);

    // chain of entry cells; each takes its upper neighbor on erase
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_WIDTH-1:0]   w_up_key;
        logic [VALUE_WIDTH-1:0] w_up_val;
        if (g < CAPACITY - 1) begin : g_mid
            assign w_up_key = w_cell_key[g+1];
            assign w_up_val = w_cell_val[g+1];
        end else begin : g_last
            // top cell falls out of range on erase; hold its contents
            assign w_up_key = w_cell_key[g];
            assign w_up_val = w_cell_val[g];
        end

        lskv_cell #(
            .INDEX       (g),
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_count    (r_count),
            .i_cmp_key  (w_cmp_key),
            .i_ctl      (w_ctl),
            .i_wr_key   (w_wr_key),
            .i_wr_value (w_rd_val),
            .i_up_key   (w_up_key),
            .i_up_value (w_up_val),
            .o_key      (w_cell_key[g]),
            .o_value    (w_cell_val[g]),
            .o_hit      (w_hit[g])
        );
    end

    lskv_match_enc #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W)
    ) u_enc (
        .i_hit   (w_hit),
        .i_value (w_cell_val),
        .o_any   (w_any),
        .o_idx   (w_idx),
        .o_value (w_val)
    );

    // In the update cycle, decide the update and build the response.
    always_comb begin
        n_count         = r_count;
        w_ctl           = '0;
        w_rd_val        = '0;
        n_rsp.found     = 1'b0;
        n_rsp.status    = lskv_pkg::ST_OK;
        unique case (r_req.opcode)
            lskv_pkg::OP_ACCESS: begin
                if (r_hit_any) begin
                    // hit: keep key, optionally overwrite value
                    n_rsp.found = 1'b1;
                    w_rd_val    = r_req.write_enable ? w_wr_data : r_hit_val;
                    w_ctl.write = r_busy;
                    w_ctl.slot  = lskv_pkg::t_slot'(r_hit_idx);
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    n_rsp.status = lskv_pkg::ST_FULL;
                end else begin
                    // miss: append at the fill point
                    w_rd_val    = r_req.write_enable ? w_wr_data : '0;
                    w_ctl.write = r_busy;
                    w_ctl.slot  = lskv_pkg::t_slot'(r_count);
                    n_count     = r_count + CNT_W'(1);
                end
            end
            lskv_pkg::OP_LOOKUP: begin
                if (r_hit_any) begin
                    n_rsp.found = 1'b1;
                    w_rd_val    = r_hit_val;
                end
            end
            lskv_pkg::OP_ERASE: begin
                if (r_hit_any) begin
                    n_rsp.found = 1'b1;
                    w_ctl.shift = r_busy;
                    w_ctl.slot  = lskv_pkg::t_slot'(r_hit_idx);
                    n_count     = r_count - CNT_W'(1);
                end else begin
                    n_rsp.status = lskv_pkg::ST_MISSING;
                end
            end
            lskv_pkg::OP_CLEAR: begin
                if (r_count == '0) begin
                    n_rsp.status = lskv_pkg::ST_EMPTY;
                end else begin
                    n_count = '0;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_rsp.read_data   = lskv_pkg::t_data'(w_rd_val);
        n_rsp.entry_count = lskv_pkg::t_count'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            // hold busy for the update cycle only
            r_busy  <= w_accept;
            r_valid <= r_busy;
            if (r_busy) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req     <= i_req;
            r_hit_any <= w_any;
            r_hit_idx <= w_idx;
            r_hit_val <= w_val;
        end
        if (r_busy) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== hdl/lskv_checker.sv =====
// Port-level checker for the key-value table, bound to the top level.
// Depends on lskv_pkg and linear_search_key_value_table.
module lskv_checker #(
    parameter int CAPACITY = lskv_pkg::DEF_CAPACITY
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_valid,
    input lskv_pkg::t_rsp o_rsp
);

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_response_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("no response after update cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.entry_count <= lskv_pkg::t_count'(CAPACITY)))
        else $error("entry count beyond capacity");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.found) |-> (o_rsp.status == lskv_pkg::ST_OK))
        else $error("found response with error status");

endmodule

bind linear_search_key_value_table lskv_checker #(
    .CAPACITY (CAPACITY)
) u_lskv_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);
